[sv/gtrr_pkg.sv]
// Shared types, codes and the 5x7 column font for the glyph text rectangle renderer.
// Has no dependencies; the renderer top level takes everything by scoped names.
package gtrr_pkg;

    // Default screen size in pixels.
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 320;

    // Character codes and glyph scan limits.
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_FIRST     = 8'd32;
    localparam logic [7:0] CODE_LAST      = 8'd127;
    localparam logic [7:0] CODE_FALLBACK  = 8'd63;
    localparam int         GLYPH_COUNT    = 96;
    localparam logic [2:0] GLYPH_COL_LAST = 3'd4;
    localparam logic [2:0] GLYPH_ROW_LAST = 3'd6;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_SCALE      = 3'd2,
        CFG_DRAW_COLOR = 3'd3
    } cfg_index_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // One clamped rectangle as it leaves the block.
    typedef struct packed {
        logic [15:0] color;
        logic [8:0]  height;
        logic [7:0]  width;
        logic [8:0]  y;
        logic [7:0]  x;
    } rect_t;

    // Font: each entry holds columns 0..4 from the most significant byte down,
    // bit 0 of a column byte is the top row.
    localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

    // Font entry for a character byte; unprintable codes fall back to '?'.
    function automatic logic [6:0] glyph_index(input logic [7:0] code);
        logic [7:0] eff;
        eff = ((code < CODE_FIRST) || (code > CODE_LAST)) ? CODE_FALLBACK : code;
        return 7'(eff - CODE_FIRST);
    endfunction

    // One column of a glyph, seven rows with the top row in bit 0.
    function automatic logic [6:0] font_column(input logic [6:0] glyph, input logic [2:0] col);
        logic [39:0] entry;
        logic [6:0]  bits;
        entry = FONT_ROM[glyph];
        case (col)
            3'd0:    bits = entry[38:32];
            3'd1:    bits = entry[30:24];
            3'd2:    bits = entry[22:16];
            3'd3:    bits = entry[14:8];
            3'd4:    bits = entry[6:0];
            default: bits = 7'd0;
        endcase
        return bits;
    endfunction

endpackage

[sv/glyph_text_rect_renderer_unit.sv]
// Glyph text rectangle renderer: turns character bytes into clamped fill rectangles.
// Depends on gtrr_pkg for the font table, state codes and the rectangle struct.
//
// Usage: character beats arrive on s_t* (tdata = char_code, tuser = restart). Each
// lit cell of the 5x7 glyph leaves on m_t* as one rectangle beat, tlast marking the
// final rectangle of the character. Configuration writes use cfg_valid/cfg_ready
// with a register index and data and are taken in any cycle; write them only while
// no character is in progress.
// Sequence: a character is accepted in the idle state and then scanned one glyph
// cell per cycle unless the scan stalls (5 columns by 7 rows, with one font column
// read ahead from the registered font port); the flush state then releases the
// held-back final rectangle and advances the cursor, and s_tready returns. A
// newline is taken in the idle state and produces no beat.
// A surviving rectangle is held back until the next surviving cell or the flush
// cycle so that tlast can be set on it; when a new survivor must push it out while the
// output register is still full, the scan stops until m_tready returns.
// Reset clears the cursor to (0,0) and loads origin (0,0), scale 1, color 0xFFFF.
module glyph_text_rect_renderer_unit #(
    parameter int SCREEN_WIDTH  = gtrr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = gtrr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Character input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] restart
    // Rectangle output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] rect_x, [16:8] rect_y, [24:17] rect_width,
                                   // [33:25] rect_height, [49:34] pixel_color, rest zero
    output logic        m_tlast,   // last
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic signed [17:0] SCR_W = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] SCR_H = 18'(SCREEN_HEIGHT);

    // Control and configuration registers.
    gtrr_pkg::state_t state_reg, state_next;
    logic [15:0] origin_x_reg, origin_x_next;
    logic [15:0] origin_y_reg, origin_y_next;
    logic [7:0]  scale_reg, scale_next;
    logic [15:0] color_reg, color_next;
    logic [15:0] cur_col_reg, cur_col_next;
    logic [15:0] cur_row_reg, cur_row_next;
    logic [2:0]  col_reg, col_next;
    logic [2:0]  row_reg, row_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_last_reg, out_last_next;

    // Payload registers.
    logic [15:0]     x_pos_reg, x_pos_next;
    logic [15:0]     y_pos_reg, y_pos_next;
    logic [6:0]      glyph_reg, glyph_next;
    logic [6:0]      font_q_reg;
    gtrr_pkg::rect_t pend_reg, pend_next;
    gtrr_pkg::rect_t out_reg, out_next;

    // Font read port.
    logic       rd_en;
    logic [6:0] rd_glyph;
    logic [2:0] rd_col;

    // Cell evaluation.
    logic signed [17:0] xe, ye, se, x0, y0, w0, h0, w1, h1;
    logic               cell_ok;
    gtrr_pkg::rect_t    cell_rect;
    logic               out_free;
    logic               stall;
    logic [15:0]        base_col, base_row;
    logic [15:0]        scale16, step6, step8;

    assign s_tready  = (state_reg == gtrr_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {6'd0, out_reg};

    assign scale16 = {8'd0, scale_reg};
    assign step6   = 16'({scale_reg, 2'b00}) + 16'({scale_reg, 1'b0});
    assign step8   = 16'({scale_reg, 3'b000});
    assign base_col = s_tuser ? origin_x_reg : cur_col_reg;
    assign base_row = s_tuser ? origin_y_reg : cur_row_reg;

    // Clamp the current cell's rectangle to the screen.
    always_comb
    begin
        xe = {{2{x_pos_reg[15]}}, x_pos_reg};
        ye = {{2{y_pos_reg[15]}}, y_pos_reg};
        se = {10'd0, scale_reg};
        if (xe < 0)
        begin
            x0 = '0;
            w0 = se + xe;
        end
        else
        begin
            x0 = xe;
            w0 = se;
        end
        if (ye < 0)
        begin
            y0 = '0;
            h0 = se + ye;
        end
        else
        begin
            y0 = ye;
            h0 = se;
        end
        w1 = (x0 + w0 > SCR_W) ? (SCR_W - x0) : w0;
        h1 = (y0 + h0 > SCR_H) ? (SCR_H - y0) : h0;
        cell_ok = font_q_reg[row_reg] && (w1 > 0) && (h1 > 0);
        cell_rect.x      = x0[7:0];
        cell_rect.y      = y0[8:0];
        cell_rect.width  = w1[7:0];
        cell_rect.height = h1[8:0];
        cell_rect.color  = color_reg;
    end

    // A new survivor pushes the held one out; that needs a free output register.
    assign out_free = !out_valid_reg || m_tready;
    assign stall    = cell_ok && pend_valid_reg && !out_free;

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        scale_next      = scale_reg;
        color_next      = color_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        x_pos_next      = x_pos_reg;
        y_pos_next      = y_pos_reg;
        glyph_next      = glyph_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_glyph        = glyph_reg;
        rd_col          = col_reg + 3'd1;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gtrr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tdata == gtrr_pkg::CODE_NEWLINE)
                    begin
                        cur_col_next = origin_x_reg;
                        cur_row_next = base_row + step8;
                    end
                    else
                    begin
                        cur_col_next = base_col;
                        cur_row_next = base_row;
                        x_pos_next   = base_col;
                        y_pos_next   = base_row;
                        col_next     = '0;
                        row_next     = '0;
                        glyph_next   = gtrr_pkg::glyph_index(s_tdata);
                        rd_en        = 1'b1;
                        rd_glyph     = gtrr_pkg::glyph_index(s_tdata);
                        rd_col       = '0;
                        state_next   = gtrr_pkg::ST_SCAN;
                    end
                end
            end
            gtrr_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    if (cell_ok)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = cell_rect;
                        pend_valid_next = 1'b1;
                    end
                    // Step to the next cell, column by column, top row first.
                    if (row_reg == gtrr_pkg::GLYPH_ROW_LAST)
                    begin
                        row_next   = '0;
                        col_next   = col_reg + 3'd1;
                        y_pos_next = cur_row_reg;
                        x_pos_next = x_pos_reg + scale16;
                        if (col_reg == gtrr_pkg::GLYPH_COL_LAST)
                        begin
                            state_next = gtrr_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                        end
                    end
                    else
                    begin
                        row_next   = row_reg + 3'd1;
                        y_pos_next = y_pos_reg + scale16;
                    end
                end
            end
            gtrr_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    cur_col_next = cur_col_reg + step6;
                    state_next   = gtrr_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    cur_col_next    = cur_col_reg + step6;
                    state_next      = gtrr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gtrr_pkg::ST_IDLE;
            end
        endcase

        // Configuration writes; unknown indexes are ignored.
        if (cfg_valid)
        begin
            case (cfg_index)
                gtrr_pkg::CFG_ORIGIN_X:   origin_x_next = cfg_data;
                gtrr_pkg::CFG_ORIGIN_Y:   origin_y_next = cfg_data;
                gtrr_pkg::CFG_SCALE:      scale_next    = cfg_data[7:0];
                gtrr_pkg::CFG_DRAW_COLOR: color_next    = cfg_data;
                default:                  ;
            endcase
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gtrr_pkg::ST_IDLE;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            scale_reg      <= 8'd1;
            color_reg      <= 16'hFFFF;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            scale_reg      <= scale_next;
            color_reg      <= color_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        x_pos_reg <= x_pos_next;
        y_pos_reg <= y_pos_next;
        glyph_reg <= glyph_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    // Font memory read port, registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            font_q_reg <= gtrr_pkg::font_column(rd_glyph, rd_col);
        end
    end

    // A held rectangle never outlives its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == gtrr_pkg::ST_SCAN || state_reg == gtrr_pkg::ST_FLUSH))
        else $error("held rectangle outside a character scan");

    // The scan position stays inside the 5x7 cell grid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gtrr_pkg::ST_SCAN) |->
            (col_reg <= gtrr_pkg::GLYPH_COL_LAST && row_reg <= gtrr_pkg::GLYPH_ROW_LAST))
        else $error("scan position out of the glyph grid");

    // Leaving the flush state always empties the hold register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gtrr_pkg::ST_FLUSH && state_next == gtrr_pkg::ST_IDLE)
            |=> !pend_valid_reg)
        else $error("rectangle lost at end of character");

endmodule

[tb/glyph_text_rect_renderer_unit_test.sv]
// Self-checking testbench for glyph_text_rect_renderer_unit: character beats in, rectangle beats out.
// A local glyph/cursor predictor builds the expected rectangles; needs gtrr_pkg and the renderer RTL.
// Directed edge cases run first, then random text lines under several idling and back-pressure phases.
module glyph_text_rect_renderer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W        = 240;
    localparam int SCREEN_H        = 320;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 12;
    localparam logic [2:0] CFG_INDEX_SPARE_FIRST = 3'd4;

    // One character beat as the driver presents it.
    typedef struct packed {
        logic [7:0] code;
        logic       restart;
    } char_beat_t;

    // One predicted rectangle beat.
    typedef struct packed {
        logic            last;
        gtrr_pkg::rect_t rect;
    } rect_beat_t;

    // 5x7 column font, column 0 in the top byte, bit 0 of a column is the top row.
    localparam logic [39:0] GLYPH_COLUMNS [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

    // Block ports.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Predictor copy of the registers and the text cursor.
    logic [15:0] origin_x_reg   = '0;
    logic [15:0] origin_y_reg   = '0;
    logic [7:0]  scale_reg      = 8'd1;
    logic [15:0] draw_color_reg = 16'hFFFF;
    logic [15:0] cursor_col     = '0;
    logic [15:0] cursor_row     = '0;

    char_beat_t      char_queue [$];
    rect_beat_t      rect_expect [$];
    char_beat_t      next_char;
    rect_beat_t      rect_want;
    gtrr_pkg::rect_t rect_got;
    logic            s_fire = 1'b0;
    int unsigned     fail_count = 0;
    int unsigned     chars_queued = 0;
    int unsigned     chars_taken  = 0;

    // Idling controls, set per phase by the stimulus.
    int unsigned send_idle_pct     = 0;
    int unsigned recv_stall_pct    = 0;
    int unsigned hold_off_requests = 0;
    int unsigned hold_off_served   = 0;
    int unsigned hold_off_left     = 0;

    glyph_text_rect_renderer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Work out the rectangles one character produces and move the cursor.
    // The newest surviving rectangle is held back so that the final one gets last set.
    function automatic void predict_glyph(input logic [7:0] code, input logic restart);
        logic [7:0]         glyph_code;
        logic [39:0]        columns;
        logic [7:0]         col_bits;
        logic signed [15:0] x16;
        logic signed [15:0] y16;
        int                 x;
        int                 y;
        int                 w;
        int                 h;
        rect_beat_t         held;
        logic               have_held;
        have_held = 1'b0;
        held      = '0;
        if (restart)
        begin
            cursor_col = origin_x_reg;
            cursor_row = origin_y_reg;
        end
        if (code == gtrr_pkg::CODE_NEWLINE)
        begin
            cursor_col = origin_x_reg;
            cursor_row = cursor_row + 16'(8 * scale_reg);
            return;
        end
        glyph_code = ((code < gtrr_pkg::CODE_FIRST) || (code > gtrr_pkg::CODE_LAST)) ?
                     gtrr_pkg::CODE_FALLBACK : code;
        columns    = GLYPH_COLUMNS[glyph_code - gtrr_pkg::CODE_FIRST];
        for (int c = 0; c < 5; c++)
        begin
            col_bits = columns[8 * (4 - c) +: 8];
            for (int r = 0; r < 7; r++)
            begin
                if (col_bits[r])
                begin
                    // Positions wrap at 16 bits and are then read as signed.
                    x16 = cursor_col + 16'(c * scale_reg);
                    y16 = cursor_row + 16'(r * scale_reg);
                    x   = x16;
                    y   = y16;
                    w   = scale_reg;
                    h   = scale_reg;
                    if (x < 0)
                    begin
                        w = w + x;
                        x = 0;
                    end
                    if (y < 0)
                    begin
                        h = h + y;
                        y = 0;
                    end
                    if (x + w > SCREEN_W)
                        w = SCREEN_W - x;
                    if (y + h > SCREEN_H)
                        h = SCREEN_H - y;
                    if (w > 0 && h > 0)
                    begin
                        if (have_held)
                            rect_expect.push_back(held);
                        held.last        = 1'b0;
                        held.rect.x      = 8'(x);
                        held.rect.y      = 9'(y);
                        held.rect.width  = 8'(w);
                        held.rect.height = 9'(h);
                        held.rect.color  = draw_color_reg;
                        have_held        = 1'b1;
                    end
                end
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            rect_expect.push_back(held);
        end
        cursor_col = cursor_col + 16'(6 * scale_reg);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Character driver: presents the next queued beat at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_fire))
        begin
            if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_char = char_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_char.code;
                s_tuser  <= next_char.restart;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Rectangle receiver: random stalls plus an occasional long hold-off.
    always @(negedge clk)
    begin
        if (hold_off_served != hold_off_requests)
        begin
            hold_off_served = hold_off_requests;
            hold_off_left   = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0)
        begin
            hold_off_left = hold_off_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: tracks register writes, predicts on each character beat, checks rectangle beats.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_fire = 1'b0;
        else
        begin
            s_fire = s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gtrr_pkg::CFG_ORIGIN_X:   origin_x_reg   = cfg_data;
                    gtrr_pkg::CFG_ORIGIN_Y:   origin_y_reg   = cfg_data;
                    gtrr_pkg::CFG_SCALE:      scale_reg      = cfg_data[7:0];
                    gtrr_pkg::CFG_DRAW_COLOR: draw_color_reg = cfg_data;
                    default:                  ;
                endcase
            end
            if (s_fire)
            begin
                predict_glyph(s_tdata, s_tuser);
                chars_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (rect_expect.size() == 0)
                begin
                    $error("rectangle beat with nothing expected: tdata=%h tlast=%b",
                           m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    rect_want = rect_expect.pop_front();
                    rect_got  = m_tdata[49:0];
                    check_field("rect_x", rect_want.rect.x, rect_got.x);
                    check_field("rect_y", rect_want.rect.y, rect_got.y);
                    check_field("rect_width", rect_want.rect.width, rect_got.width);
                    check_field("rect_height", rect_want.rect.height, rect_got.height);
                    check_field("pixel_color", rect_want.rect.color, rect_got.color);
                    check_field("last", rect_want.last, m_tlast);
                    check_field("tdata_pad", 0, m_tdata[55:50]);
                end
            end
        end
    end

    task automatic queue_char(input logic [7:0] char_code, input logic restart_bit);
        char_beat_t beat;
        beat.code    = char_code;
        beat.restart = restart_bit;
        char_queue.push_back(beat);
        chars_queued++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued character is accepted and every rectangle has arrived,
    // then let a character that draws nothing finish inside the block.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (chars_taken != chars_queued || rect_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Watchdog.
    initial
    begin
        #8ms;
        $display("status: fail");
        $finish;
    end

    // Stimulus.
    initial
    begin
        int unsigned line_left;
        int unsigned mode;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: normal glyphs, blank space, last code, unprintable codes, newline.
        queue_char("A", 1'b1);
        queue_char(" ", 1'b0);
        queue_char(gtrr_pkg::CODE_LAST, 1'b0);
        queue_char(8'd0, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(gtrr_pkg::CODE_NEWLINE, 1'b0);
        queue_char(8'd31, 1'b0);
        queue_char(8'd128, 1'b0);
        queue_char("~", 1'b0);
        queue_char("!", 1'b0);
        wait_for_drain();

        // Indexes past the register list must be ignored.
        for (int i = CFG_INDEX_SPARE_FIRST; i < 8; i++)
            write_reg(3'(i), 16'($urandom));

        // Origin slightly above and left of the screen: clamping at the top and left.
        write_reg(gtrr_pkg::CFG_ORIGIN_X, 16'(-3));
        write_reg(gtrr_pkg::CFG_ORIGIN_Y, 16'(-5));
        write_reg(gtrr_pkg::CFG_SCALE, 16'd2);
        write_reg(gtrr_pkg::CFG_DRAW_COLOR, 16'h0000);
        queue_char("W", 1'b1);
        queue_char(gtrr_pkg::CODE_NEWLINE, 1'b1);
        queue_char("M", 1'b0);
        wait_for_drain();

        // Zero scale draws nothing and characters leave the cursor in place.
        write_reg(gtrr_pkg::CFG_SCALE, 16'd0);
        queue_char("A", 1'b0);
        queue_char(gtrr_pkg::CODE_NEWLINE, 1'b0);
        queue_char("B", 1'b1);
        wait_for_drain();

        // Largest scale near the bottom right corner, then fully off screen.
        write_reg(gtrr_pkg::CFG_ORIGIN_X, 16'd200);
        write_reg(gtrr_pkg::CFG_ORIGIN_Y, 16'd300);
        write_reg(gtrr_pkg::CFG_SCALE, 16'd255);
        write_reg(gtrr_pkg::CFG_DRAW_COLOR, 16'hF81F);
        queue_char("#", 1'b1);
        queue_char("A", 1'b0);
        wait_for_drain();

        // Large negative origin: cells partly cut at the top left.
        write_reg(gtrr_pkg::CFG_ORIGIN_X, 16'(-200));
        write_reg(gtrr_pkg::CFG_ORIGIN_Y, 16'(-250));
        queue_char("@", 1'b1);
        wait_for_drain();

        // Signed extremes: coordinate and cursor wrap at 16 bits.
        write_reg(gtrr_pkg::CFG_ORIGIN_X, 16'h7FFF);
        write_reg(gtrr_pkg::CFG_ORIGIN_Y, 16'h8000);
        queue_char("A", 1'b1);
        queue_char(gtrr_pkg::CODE_NEWLINE, 1'b0);
        queue_char("B", 1'b0);
        wait_for_drain();

        // Unit scale right at the screen edge.
        write_reg(gtrr_pkg::CFG_ORIGIN_X, 16'd236);
        write_reg(gtrr_pkg::CFG_ORIGIN_Y, 16'd313);
        write_reg(gtrr_pkg::CFG_SCALE, 16'd1);
        queue_char("E", 1'b1);
        wait_for_drain();

        // Random text lines with some noise, one setting and idling mode per phase.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if ($urandom_range(9) < 7)
                write_reg(gtrr_pkg::CFG_SCALE, 16'($urandom_range(3, 1)));
            else if ($urandom_range(1) == 0)
                write_reg(gtrr_pkg::CFG_SCALE, 16'($urandom_range(12, 4)));
            else
                write_reg(gtrr_pkg::CFG_SCALE, 16'($urandom_range(255)));
            if ($urandom_range(9) < 8)
                write_reg(gtrr_pkg::CFG_ORIGIN_X, 16'($urandom_range(200)));
            else
                write_reg(gtrr_pkg::CFG_ORIGIN_X, 16'($urandom));
            if ($urandom_range(9) < 8)
                write_reg(gtrr_pkg::CFG_ORIGIN_Y, 16'($urandom_range(300)));
            else
                write_reg(gtrr_pkg::CFG_ORIGIN_Y, 16'($urandom));
            write_reg(gtrr_pkg::CFG_DRAW_COLOR, 16'($urandom));

            mode           = p % 4;
            send_idle_pct  = (mode == 1) ? 78 : (mode == 3) ? 36 : 0;
            recv_stall_pct = (mode == 2) ? 78 : (mode == 3) ? 36 : 0;

            line_left = $urandom_range(12, 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == 0)
                    queue_char(8'($urandom_range(gtrr_pkg::CODE_LAST, gtrr_pkg::CODE_FIRST)),
                               1'b1);
                else if ($urandom_range(99) < 15)
                    queue_char(8'($urandom_range(255)), 1'($urandom_range(1)));
                else if (line_left == 0)
                begin
                    queue_char(gtrr_pkg::CODE_NEWLINE, $urandom_range(7) == 0);
                    line_left = $urandom_range(12, 3);
                end
                else
                begin
                    queue_char(8'($urandom_range(gtrr_pkg::CODE_LAST, gtrr_pkg::CODE_FIRST)),
                               1'b0);
                    line_left--;
                end
                // Sender pauses halfway until every rectangle is back.
                if (p == 1 && i == PHASE_ITEMS / 2)
                    wait_for_drain();
            end
            // Long receiver hold-off while characters keep coming, so the block backs up.
            if (p == 0)
                hold_off_requests++;
            wait_for_drain();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
sv/gtrr_pkg.sv
sv/glyph_text_rect_renderer_unit.sv
tb/glyph_text_rect_renderer_unit_test.sv
